@@ sv/resp_request_deframer_defines.svh @@
`ifndef RESP_REQUEST_DEFRAMER_DEFINES_SVH
`define RESP_REQUEST_DEFRAMER_DEFINES_SVH

// check cons in the same cycle as ante, outside reset
`define RRD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check cons in the cycle after ante, outside reset
`define RRD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// check cons in the cycle after reset is applied
`define RRD_ASSERT_RST(label, clk, rst_n, cons, msg) \
    label: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/rrd_pkg.sv @@
package rrd_pkg;

    localparam logic [1:0] EV_PAYLOAD   = 2'd0;
    localparam logic [1:0] EV_FIELD_END = 2'd1;
    localparam logic [1:0] EV_ERROR     = 2'd2;

    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_BAD_PREFIX = 3'd1;
    localparam logic [2:0] ERR_BAD_DIGIT  = 3'd2;
    localparam logic [2:0] ERR_MISSING_LF = 3'd3;
    localparam logic [2:0] ERR_COUNT      = 3'd4;
    localparam logic [2:0] ERR_LENGTH     = 3'd5;
    localparam logic [2:0] ERR_DIGITS     = 3'd6;

    localparam logic REG_MAX_FIELDS    = 1'b0;
    localparam logic REG_MAX_FIELD_LEN = 1'b1;

    localparam logic [10:0] MAX_FIELDS_RESET    = 11'd1024;
    localparam logic [31:0] MAX_FIELD_LEN_RESET = 32'd536870912;

    localparam logic [7:0] CHR_STAR   = 8'h2A;
    localparam logic [7:0] CHR_DOLLAR = 8'h24;
    localparam logic [7:0] CHR_CR     = 8'h0D;
    localparam logic [7:0] CHR_LF     = 8'h0A;
    localparam logic [7:0] CHR_ZERO   = 8'h30;
    localparam logic [7:0] CHR_NINE   = 8'h39;

    typedef struct packed {
        logic [1:0]  event_res;
        logic [7:0]  data_byte;
        logic [9:0]  field_index;
        logic        req_last;
        logic [10:0] field_total;
        logic [2:0]  error_code;
    } rrd_result_t;

endpackage

@@ sv/resp_request_deframer.sv @@
// Request deframer for arrays of bulk strings: '*' count CRLF, then per field
// '$' length CRLF, payload, CRLF.
// s_ channel: one request byte per transfer in s_tdata[7:0].
// m_ channel: one result per payload byte, per field end (closing LF) and per
// protocol error. m_tuser carries the event kind, m_tlast marks the field end
// that completes the request. Header bytes and the CR after a payload give
// no result. After an error the parser waits for the next '*'.
// cfg_wr_en/cfg_index/cfg_wdata write max_fields (index 0) and
// max_field_len (index 1); write only while the block is idle.
// Results are registered in the output buffer before they appear on m_.
// Throughput: one byte per cycle while s_tready is high.
// A two-entry output buffer takes one further result while m_tready is low;
// s_tready drops once that entry is full and rises when it drains.
// Reset: parser awaits '*', max_fields = 1024, max_field_len = 2^29, and the
// output buffer is empty.
module resp_request_deframer
    import rrd_pkg::*;
#(
    parameter int MAX_FIELDS = 1024,
    parameter int LEN_BITS   = 32,
    parameter int MAX_DIGITS = 30
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // byte_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // data_byte, field_index, field_total, error_code
    output logic [1:0]  m_tuser,   // event_res
    output logic        m_tlast    // req_last
);

    logic        byte_valid;
    logic        res_valid;
    rrd_result_t res;
    rrd_result_t out_res;

    assign byte_valid = s_tvalid && s_tready;

    rrd_parser #(
        .MAX_FIELDS (MAX_FIELDS),
        .LEN_BITS   (LEN_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .byte_valid (byte_valid),
        .byte_in    (s_tdata),
        .res_valid  (res_valid),
        .res        (res)
    );

    rrd_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_res    (res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_res   (out_res),
        .out_ready (m_tready)
    );

    assign m_tdata = {out_res.error_code, out_res.field_total,
                      out_res.field_index, out_res.data_byte};
    assign m_tuser = out_res.event_res;
    assign m_tlast = out_res.req_last;

endmodule

@@ sv/rrd_parser.sv @@
module rrd_parser
    import rrd_pkg::*;
#(
    parameter int MAX_FIELDS = 1024,
    parameter int LEN_BITS   = 32,
    parameter int MAX_DIGITS = 30
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        byte_valid,
    input  logic [7:0]  byte_in,
    output logic        res_valid,
    output rrd_result_t res
);

    localparam int CMP_W = (LEN_BITS > 32) ? LEN_BITS : 32;
    localparam int PROD_W = LEN_BITS + 4;

    typedef enum logic [3:0] {
        PH_STAR,
        PH_CNT_DIG,
        PH_CNT_LF,
        PH_DOLLAR,
        PH_LEN_DIG,
        PH_LEN_LF,
        PH_PAYLOAD,
        PH_PAY_CR,
        PH_PAY_LF
    } phase_t;

    phase_t               phase_reg, phase_next;
    logic [LEN_BITS-1:0]  accum_reg, accum_next;
    logic [4:0]           digits_reg, digits_next;
    logic                 ovf_reg, ovf_next;
    logic [10:0]          total_reg, total_next;
    logic [10:0]          field_reg, field_next;
    logic [LEN_BITS-1:0]  remain_reg, remain_next;
    logic [10:0]          max_fields_reg;
    logic [31:0]          max_len_reg;

    logic                 is_digit;
    logic [PROD_W-1:0]    acc_sum;
    logic                 acc_fits;
    logic [CMP_W-1:0]     acc_w;
    logic [LEN_BITS-1:0]  remain_dec;
    logic                 num_fail;
    logic [2:0]           num_err;
    logic                 num_done;
    logic                 fail;
    logic [2:0]           fail_code;

    assign is_digit = (byte_in >= CHR_ZERO) && (byte_in <= CHR_NINE);
    assign acc_sum  = (PROD_W'(accum_reg) << 3) + (PROD_W'(accum_reg) << 1)
                      + PROD_W'(byte_in[3:0]);
    assign acc_fits = (acc_sum[PROD_W-1:LEN_BITS] == 4'd0);
    assign acc_w    = CMP_W'(accum_reg);
    assign remain_dec = (remain_reg != '0) ? remain_reg - LEN_BITS'(1) : remain_reg;

    always_comb begin
        num_fail = 1'b0;
        num_err  = ERR_NONE;
        num_done = 1'b0;
        if (byte_in == CHR_CR) begin
            if (digits_reg == 5'd0) begin
                num_fail = 1'b1;
                num_err  = ERR_BAD_DIGIT;
            end else begin
                num_done = 1'b1;
            end
        end else if (!is_digit) begin
            num_fail = 1'b1;
            num_err  = ERR_BAD_DIGIT;
        end else if (digits_reg >= 5'(MAX_DIGITS)) begin
            num_fail = 1'b1;
            num_err  = ERR_DIGITS;
        end
    end

    always_comb begin
        phase_next  = phase_reg;
        accum_next  = accum_reg;
        digits_next = digits_reg;
        ovf_next    = ovf_reg;
        total_next  = total_reg;
        field_next  = field_reg;
        remain_next = remain_reg;
        fail        = 1'b0;
        fail_code   = ERR_NONE;
        res_valid   = 1'b0;
        res.event_res   = EV_PAYLOAD;
        res.data_byte   = 8'd0;
        res.field_index = field_reg[9:0];
        res.req_last    = 1'b0;
        res.field_total = total_reg;
        res.error_code  = ERR_NONE;

        case (phase_reg)
            PH_STAR: begin
                if (byte_in != CHR_STAR) begin
                    fail      = 1'b1;
                    fail_code = ERR_BAD_PREFIX;
                end else begin
                    accum_next  = '0;
                    digits_next = 5'd0;
                    ovf_next    = 1'b0;
                    phase_next  = PH_CNT_DIG;
                end
            end
            PH_CNT_DIG, PH_LEN_DIG: begin
                if (num_fail) begin
                    fail      = 1'b1;
                    fail_code = num_err;
                end else if (num_done) begin
                    phase_next = (phase_reg == PH_CNT_DIG) ? PH_CNT_LF : PH_LEN_LF;
                end else begin
                    digits_next = digits_reg + 5'd1;
                    if (ovf_reg || !acc_fits) begin
                        ovf_next = 1'b1;
                    end else begin
                        accum_next = acc_sum[LEN_BITS-1:0];
                    end
                end
            end
            PH_CNT_LF: begin
                if (byte_in != CHR_LF) begin
                    fail      = 1'b1;
                    fail_code = ERR_MISSING_LF;
                end else if (ovf_reg || (acc_w == '0) || (acc_w > CMP_W'(max_fields_reg))
                             || (acc_w > CMP_W'(MAX_FIELDS))) begin
                    fail      = 1'b1;
                    fail_code = ERR_COUNT;
                end else begin
                    total_next  = acc_w[10:0];
                    field_next  = 11'd0;
                    accum_next  = '0;
                    digits_next = 5'd0;
                    ovf_next    = 1'b0;
                    phase_next  = PH_DOLLAR;
                end
            end
            PH_DOLLAR: begin
                if (byte_in != CHR_DOLLAR) begin
                    fail      = 1'b1;
                    fail_code = ERR_BAD_PREFIX;
                end else begin
                    accum_next  = '0;
                    digits_next = 5'd0;
                    ovf_next    = 1'b0;
                    phase_next  = PH_LEN_DIG;
                end
            end
            PH_LEN_LF: begin
                if (byte_in != CHR_LF) begin
                    fail      = 1'b1;
                    fail_code = ERR_MISSING_LF;
                end else if (ovf_reg || (acc_w > CMP_W'(max_len_reg))) begin
                    fail      = 1'b1;
                    fail_code = ERR_LENGTH;
                end else begin
                    remain_next = accum_reg;
                    accum_next  = '0;
                    digits_next = 5'd0;
                    ovf_next    = 1'b0;
                    phase_next  = (accum_reg != '0) ? PH_PAYLOAD : PH_PAY_CR;
                end
            end
            PH_PAYLOAD: begin
                res_valid     = 1'b1;
                res.data_byte = byte_in;
                remain_next   = remain_dec;
                if (remain_dec == '0) begin
                    phase_next = PH_PAY_CR;
                end
            end
            PH_PAY_CR: begin
                if (byte_in != CHR_CR) begin
                    fail      = 1'b1;
                    fail_code = ERR_MISSING_LF;
                end else begin
                    phase_next = PH_PAY_LF;
                end
            end
            PH_PAY_LF: begin
                if (byte_in != CHR_LF) begin
                    fail      = 1'b1;
                    fail_code = ERR_MISSING_LF;
                end else begin
                    res_valid     = 1'b1;
                    res.event_res = EV_FIELD_END;
                    if (({1'b0, field_reg} + 12'd1) >= {1'b0, total_reg}) begin
                        res.req_last = 1'b1;
                        field_next   = 11'd0;
                        phase_next   = PH_STAR;
                    end else begin
                        field_next = field_reg + 11'd1;
                        phase_next = PH_DOLLAR;
                    end
                end
            end
            default: begin
                fail      = 1'b1;
                fail_code = ERR_BAD_PREFIX;
            end
        endcase

        // drop the byte and resynchronise
        if (fail) begin
            res_valid      = 1'b1;
            res.event_res  = EV_ERROR;
            res.data_byte  = 8'd0;
            res.req_last   = 1'b0;
            res.error_code = fail_code;
            phase_next     = PH_STAR;
            accum_next     = '0;
            digits_next    = 5'd0;
            ovf_next       = 1'b0;
            field_next     = 11'd0;
        end

        if (!byte_valid) begin
            res_valid = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_STAR;
            accum_reg      <= '0;
            digits_reg     <= 5'd0;
            ovf_reg        <= 1'b0;
            total_reg      <= 11'd0;
            field_reg      <= 11'd0;
            remain_reg     <= '0;
            max_fields_reg <= MAX_FIELDS_RESET;
            max_len_reg    <= MAX_FIELD_LEN_RESET;
        end else begin
            if (byte_valid) begin
                phase_reg  <= phase_next;
                accum_reg  <= accum_next;
                digits_reg <= digits_next;
                ovf_reg    <= ovf_next;
                total_reg  <= total_next;
                field_reg  <= field_next;
                remain_reg <= remain_next;
            end
            if (cfg_wr_en && (cfg_index == REG_MAX_FIELDS)) begin
                max_fields_reg <= cfg_wdata[10:0];
            end
            if (cfg_wr_en && (cfg_index == REG_MAX_FIELD_LEN)) begin
                max_len_reg <= cfg_wdata;
            end
        end
    end

endmodule

@@ sv/rrd_out_buf.sv @@
module rrd_out_buf
    import rrd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    input  rrd_result_t in_res,
    output logic        in_ready,
    output logic        out_valid,
    output rrd_result_t out_res,
    input  logic        out_ready
);

    rrd_result_t out_reg;
    rrd_result_t skid_reg;
    logic        out_valid_reg;
    logic        skid_valid_reg;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_ready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_reg        <= skid_reg;
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_reg       <= in_res;
                out_valid_reg <= in_valid;
            end
        end else if (in_valid) begin
            // hold the stalled result, park the new one
            skid_reg       <= in_res;
            skid_valid_reg <= 1'b1;
        end
    end

endmodule

@@ sv/rrd_checker.sv @@
`include "resp_request_deframer_defines.svh"

module rrd_checker
    import rrd_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    `RRD_ASSERT_RST(a_reset_empty, aclk, aresetn, !m_tvalid, "result valid after reset")

    `RRD_ASSERT_NXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast),
        "stalled result changed")

    `RRD_ASSERT_IMP(a_error_shape, aclk, aresetn, m_tvalid && (m_tuser == EV_ERROR),
        !m_tlast && (m_tdata[7:0] == 8'd0) && (m_tdata[31:29] != ERR_NONE),
        "malformed error result")

    `RRD_ASSERT_IMP(a_last_on_end, aclk, aresetn, m_tvalid && m_tlast,
        (m_tuser == EV_FIELD_END) && (m_tdata[31:29] == ERR_NONE),
        "last flag outside a field end")

    `RRD_ASSERT_IMP(a_payload_clean, aclk, aresetn, m_tvalid && (m_tuser == EV_PAYLOAD),
        (m_tdata[31:29] == ERR_NONE),
        "payload byte carries an error code")

endmodule

bind resp_request_deframer rrd_checker u_rrd_checker (.*);
